### design/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// shared types and constants for the sorted timer table
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned ID_W    = 22;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_REMOVE_ID  = 2'd1,
    OP_REMOVE_POS = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  // control shared by every cell of the row
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic del_en;
    logic rm_id;
  } cell_ctrl_t;

endpackage : stt_pkg
`default_nettype wire

### design/stt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stt_cell
// one table slot: holds an entry, compares it with the request and shifts
// ----------------------------------------------------------------------------
module stt_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire stt_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic [stt_pkg::TIME_W-1:0] req_time_i,
  input  wire logic [stt_pkg::ID_W-1:0]   req_id_i,
  input  wire logic                       live_i,
  input  wire logic                       pos_ge_i,
  input  wire logic                       pos_eq_i,
  input  wire logic [stt_pkg::TIME_W-1:0] left_time_i,
  input  wire logic [stt_pkg::ID_W-1:0]   left_id_i,
  input  wire logic                       left_le_i,
  input  wire logic [stt_pkg::TIME_W-1:0] right_time_i,
  input  wire logic [stt_pkg::ID_W-1:0]   right_id_i,
  input  wire logic                       hit_i,
  output logic [stt_pkg::TIME_W-1:0]      time_o,
  output logic [stt_pkg::ID_W-1:0]        id_o,
  output logic                            le_o,
  output logic                            hit_o,
  output logic                            sel_o
);
  import stt_pkg::*;

  logic [TIME_W-1:0] time_q, time_d;
  logic [ID_W-1:0]   id_q, id_d;
  logic              le_q, match_q;
  logic              kill;

  assign hit_o  = hit_i | match_q;
  assign kill   = ctrl_i.rm_id ? hit_o : pos_ge_i;
  // first matching slot for remove by id, addressed slot otherwise
  assign sel_o  = ctrl_i.rm_id ? (match_q & ~hit_i) : pos_eq_i;
  assign le_o   = le_q;
  assign time_o = time_q;
  assign id_o   = id_q;

  always_comb begin
    time_d = time_q;
    id_d   = id_q;
    if (ctrl_i.ins_en && !le_q) begin
      // slot at the insert point takes the request, later slots move up
      time_d = left_le_i ? req_time_i : left_time_i;
      id_d   = left_le_i ? req_id_i : left_id_i;
    end else if (ctrl_i.del_en && kill) begin
      time_d = right_time_i;
      id_d   = right_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      le_q    <= 1'b0;
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      le_q    <= live_i && (time_q <= req_time_i);
      match_q <= live_i && (id_q == req_id_i);
    end
  end

  always_ff @(posedge clk_i) begin
    time_q <= time_d;
    id_q   <= id_d;
  end

endmodule : stt_cell
`default_nettype wire

### design/sorted_timer_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_table_unit
// alarm table kept sorted by time in a row of compare-and-shift cells
// ----------------------------------------------------------------------------
// Each request passes through a compare state, in which every cell compares
// its entry with the request, and an update state, in which the row shifts
// and the result is formed; the block then returns to idle with done_o high
// and the result. A new request is taken while the result is shown, and none
// while busy. busy is high from the cycle after a request is accepted until
// the result appears; the result is shown for one cycle only and the receiver
// must take it then.
module sorted_timer_table_unit #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [stt_pkg::OP_W-1:0]   operation_i,
  input  wire logic [stt_pkg::TIME_W-1:0] alarm_time_i,
  input  wire logic [stt_pkg::ID_W-1:0]   alarm_id_i,
  input  wire logic [stt_pkg::POS_W-1:0]  position_i,
  output logic                            done_o,
  output logic [stt_pkg::STAT_W-1:0]      status_o,
  output logic [stt_pkg::COUNT_W-1:0]     entry_count_o,
  output logic [stt_pkg::ID_W-1:0]        found_id_o,
  output logic [stt_pkg::TIME_W-1:0]      found_time_o
);
  import stt_pkg::*;

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_e;

  state_e            state_q;
  logic [OP_W-1:0]   op_q;
  logic [TIME_W-1:0] req_time_q;
  logic [ID_W-1:0]   req_id_q;
  logic [POS_W-1:0]  req_pos_q;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              done_q;
  logic [STAT_W-1:0] status_q, status_d;
  logic [COUNT_W-1:0] ecount_q;
  logic [ID_W-1:0]   fid_q, fid_d;
  logic [TIME_W-1:0] ftime_q, ftime_d;

  cell_ctrl_t        ctrl;
  logic              upd, full, pos_ok, hit_any;
  logic [ID_W-1:0]   sel_id;
  logic [TIME_W-1:0] sel_time;

  logic [TIME_W-1:0] time_w [TABLE_DEPTH];
  logic [ID_W-1:0]   id_w   [TABLE_DEPTH];
  logic              le_w   [TABLE_DEPTH];
  logic              sel_w  [TABLE_DEPTH];
  logic              hit_w  [TABLE_DEPTH+1];

  assign upd     = (state_q == S_UPD);
  assign full    = (count_q == CNT_W'(TABLE_DEPTH));
  assign pos_ok  = CW'(req_pos_q) < CW'(count_q);
  assign hit_any = hit_w[TABLE_DEPTH];
  assign hit_w[0] = 1'b0;

  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.rm_id  = (op_q == OP_REMOVE_ID);
    ctrl.ins_en = upd && (op_q == OP_INSERT) && !full;
    ctrl.del_en = upd && (((op_q == OP_REMOVE_ID) && hit_any) ||
                          ((op_q == OP_REMOVE_POS) && pos_ok));
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [TIME_W-1:0] l_time, r_time;
    logic [ID_W-1:0]   l_id, r_id;
    logic              l_le;

    if (i == 0) begin : g_first
      assign l_time = req_time_q;
      assign l_id   = req_id_q;
      assign l_le   = 1'b1;
    end else begin : g_mid
      assign l_time = time_w[i-1];
      assign l_id   = id_w[i-1];
      assign l_le   = le_w[i-1];
    end

    if (i == TABLE_DEPTH - 1) begin : g_last
      assign r_time = time_w[i];
      assign r_id   = id_w[i];
    end else begin : g_inner
      assign r_time = time_w[i+1];
      assign r_id   = id_w[i+1];
    end

    stt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .req_time_i  (req_time_q),
      .req_id_i    (req_id_q),
      .live_i      (CNT_W'(i) < count_q),
      .pos_ge_i    (CW'(i) >= CW'(req_pos_q)),
      .pos_eq_i    (CW'(i) == CW'(req_pos_q)),
      .left_time_i (l_time),
      .left_id_i   (l_id),
      .left_le_i   (l_le),
      .right_time_i(r_time),
      .right_id_i  (r_id),
      .hit_i       (hit_w[i]),
      .time_o      (time_w[i]),
      .id_o        (id_w[i]),
      .le_o        (le_w[i]),
      .hit_o       (hit_w[i+1]),
      .sel_o       (sel_w[i])
    );
  end

  // select lines are one-hot at most, so the entries can be or-ed together
  always_comb begin
    sel_id   = '0;
    sel_time = '0;
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
      sel_id   = sel_id   | (sel_w[k] ? id_w[k]   : '0);
      sel_time = sel_time | (sel_w[k] ? time_w[k] : '0);
    end
  end

  always_comb begin
    count_d  = count_q;
    status_d = ST_DONE;
    fid_d    = '0;
    ftime_d  = '0;
    case (op_q)
      OP_INSERT: begin
        if (full) status_d = ST_FULL;
        else      count_d  = count_q + CNT_W'(1);
      end
      OP_REMOVE_ID: begin
        if (hit_any) begin
          count_d = count_q - CNT_W'(1);
          fid_d   = sel_id;
          ftime_d = sel_time;
        end else begin
          status_d = ST_ERROR;
        end
      end
      OP_REMOVE_POS, OP_READ: begin
        if (pos_ok) begin
          if (op_q == OP_REMOVE_POS) count_d = count_q - CNT_W'(1);
          fid_d   = sel_id;
          ftime_d = sel_time;
        end else begin
          status_d = ST_ERROR;
        end
      end
      default: status_d = ST_ERROR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= '0;
      ecount_q <= '0;
      fid_q    <= '0;
      ftime_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) state_q <= S_CMP;
        end
        S_CMP: state_q <= S_UPD;
        S_UPD: begin
          state_q  <= S_IDLE;
          count_q  <= count_d;
          done_q   <= 1'b1;
          status_q <= status_d;
          ecount_q <= COUNT_W'(count_d);
          fid_q    <= fid_d;
          ftime_q  <= ftime_d;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q       <= operation_i;
      req_time_q <= alarm_time_i;
      req_id_q   <= alarm_id_i;
      req_pos_q  <= position_i;
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign entry_count_o = ecount_q;
  assign found_id_o    = fid_q;
  assign found_time_o  = ftime_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("live count above table depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && state_q == S_CMP))
    else $error("accepted request did not enter compare");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_FULL) |-> (count_q == CNT_W'(TABLE_DEPTH)))
    else $error("full reported on a table that is not full");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_UPD) |=> $stable(count_q))
    else $error("live count changed outside the update cycle");
`endif

endmodule : sorted_timer_table_unit
`default_nettype wire

### verif/tb_sorted_timer_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_timer_table_unit
// self-checking bench for the sorted alarm table
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty table, the extremes of
// time and id, equal times, duplicate ids and the full table. Random requests
// follow, in bursts with random gaps. The phases lean first towards inserts
// and then towards removals, so the table keeps filling and draining. Each
// accepted request is run through a local model of the table. Every result
// strobe is checked field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_sorted_timer_table_unit;
  import stt_pkg::*;

  localparam int DEPTH      = 16;
  localparam int N_RANDOM   = 525;
  localparam int MAX_REPORT = 10;

  typedef struct packed {
    status_e              st;
    logic [COUNT_W-1:0]   cnt;
    logic [ID_W-1:0]      fid;
    logic [TIME_W-1:0]    ftime;
  } alarm_result_t;

  typedef struct {
    op_e                op;
    logic [TIME_W-1:0]  t;
    logic [ID_W-1:0]    id;
    logic [POS_W-1:0]   pos;
    bit                 typed;
    alarm_result_t      res;
  } dir_row_t;

  localparam int N_DIR = 26;

  // rows with typed = 0 are checked against the model of the table
  dir_row_t dir_rows [N_DIR] = '{
    '{OP_READ,       32'd0,          22'd0,        4'd0,  1'b1, '{ST_ERROR, 5'd0, 22'd0, 32'd0}},
    '{OP_REMOVE_POS, 32'd0,          22'd0,        4'd15, 1'b1, '{ST_ERROR, 5'd0, 22'd0, 32'd0}},
    '{OP_REMOVE_ID,  32'd0,          22'h3FFFFF,   4'd0,  1'b1, '{ST_ERROR, 5'd0, 22'd0, 32'd0}},
    '{OP_INSERT,     32'hFFFFFFFF,   22'h3FFFFF,   4'd15, 1'b1, '{ST_DONE,  5'd1, 22'd0, 32'd0}},
    '{OP_INSERT,     32'd0,          22'd0,        4'd0,  1'b1, '{ST_DONE,  5'd2, 22'd0, 32'd0}},
    '{OP_READ,       32'd0,          22'd0,        4'd1,  1'b1,
      '{ST_DONE, 5'd2, 22'h3FFFFF, 32'hFFFFFFFF}},
    '{OP_READ,       32'd0,          22'd0,        4'd2,  1'b1, '{ST_ERROR, 5'd2, 22'd0, 32'd0}},
    '{OP_INSERT,     32'd1000,       22'd5,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd1000,       22'd6,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd1000,       22'd5,        4'd0,  1'b0, '0},
    '{OP_READ,       32'd0,          22'd0,        4'd3,  1'b0, '0},
    '{OP_REMOVE_ID,  32'd0,          22'd5,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'hAAAAAAAA,   22'h155555,   4'd0,  1'b0, '0},
    '{OP_INSERT,     32'h55555555,   22'h2AAAAA,   4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd7,          22'd1,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd1000,       22'd2,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'hFFFFFFFF,   22'd3,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd3,          22'd4,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'h80000000,   22'h200000,   4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd0,          22'd7,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd42,         22'h3FFFFF,   4'd0,  1'b0, '0},
    '{OP_INSERT,     32'h7FFFFFFF,   22'd8,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd999,        22'd9,        4'd0,  1'b0, '0},
    '{OP_INSERT,     32'd1001,       22'd10,       4'd0,  1'b0, '0},
    '{OP_INSERT,     32'hFFFFFFFE,   22'd11,       4'd0,  1'b1, '{ST_FULL, 5'd16, 22'd0, 32'd0}},
    '{OP_REMOVE_POS, 32'd0,          22'd0,        4'd15, 1'b0, '0}
  };

  logic               clk_i;
  logic               rst_ni     = 1'b0;
  logic               start      = 1'b0;
  op_e                req_op     = OP_INSERT;
  logic [TIME_W-1:0]  req_time   = '0;
  logic [ID_W-1:0]    req_id     = '0;
  logic [POS_W-1:0]   req_pos    = '0;
  // typed expectation travelling alongside the request
  bit                 req_typed  = 1'b0;
  alarm_result_t      req_exp    = '0;

  logic               busy;
  logic               done_o;
  logic [STAT_W-1:0]  status_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic [ID_W-1:0]    found_id_o;
  logic [TIME_W-1:0]  found_time_o;

  // model of the table
  logic [TIME_W-1:0]  tbl_time [DEPTH];
  logic [ID_W-1:0]    tbl_id   [DEPTH];
  int                 tbl_count = 0;

  alarm_result_t      pending_results [$];
  int                 n_bad = 0;

  sorted_timer_table_unit #(
    .TABLE_DEPTH(DEPTH)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (req_op),
    .alarm_time_i  (req_time),
    .alarm_id_i    (req_id),
    .position_i    (req_pos),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .found_id_o    (found_id_o),
    .found_time_o  (found_time_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // close the gap left at position p
  function automatic void drop_entry(int p);
    for (int i = p; i + 1 < tbl_count; i++) begin
      tbl_time[i] = tbl_time[i + 1];
      tbl_id[i]   = tbl_id[i + 1];
    end
    tbl_count--;
  endfunction

  function automatic alarm_result_t apply_request(op_e op, logic [TIME_W-1:0] t,
                                                  logic [ID_W-1:0] id,
                                                  logic [POS_W-1:0] pos);
    alarm_result_t r;
    int            p;
    bit            hit;
    r    = '0;
    r.st = ST_DONE;
    p    = 0;
    hit  = 1'b0;
    case (op)
      OP_INSERT: begin
        if (tbl_count >= DEPTH) begin
          r.st = ST_FULL;
        end else begin
          // new entry goes after every entry of equal time
          while (p < tbl_count && tbl_time[p] <= t) p++;
          for (int i = tbl_count; i > p; i--) begin
            tbl_time[i] = tbl_time[i - 1];
            tbl_id[i]   = tbl_id[i - 1];
          end
          tbl_time[p] = t;
          tbl_id[p]   = id;
          tbl_count++;
        end
      end
      OP_REMOVE_ID: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (!hit && tbl_id[i] == id) begin
            hit = 1'b1;
            p   = i;
          end
        end
        if (hit) begin
          r.fid   = tbl_id[p];
          r.ftime = tbl_time[p];
          drop_entry(p);
        end else begin
          r.st = ST_ERROR;
        end
      end
      default: begin
        if (int'(pos) < tbl_count) begin
          r.fid   = tbl_id[pos];
          r.ftime = tbl_time[pos];
          if (op == OP_REMOVE_POS) drop_entry(int'(pos));
        end else begin
          r.st = ST_ERROR;
        end
      end
    endcase
    r.cnt = COUNT_W'(tbl_count);
    return r;
  endfunction

  // results first, so a strobe is never matched against the request taken
  // at the same edge
  always @(posedge clk_i) begin : result_check
    alarm_result_t want;
    alarm_result_t fresh;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_results.size() == 0) begin
          if (n_bad < MAX_REPORT)
            $display("%0t: result with no request outstanding: status %0d count %0d",
                     $realtime, status_o, entry_count_o);
          n_bad++;
        end else begin
          want = pending_results.pop_front();
          if (status_o !== want.st || entry_count_o !== want.cnt ||
              found_id_o !== want.fid || found_time_o !== want.ftime) begin
            if (n_bad < MAX_REPORT) begin
              $write("%0t: expected status %0d count %0d id %h time %h, ",
                     $realtime, want.st, want.cnt, want.fid, want.ftime);
              $display("got status %0d count %0d id %h time %h",
                       status_o, entry_count_o, found_id_o, found_time_o);
            end
            n_bad++;
          end
        end
      end
      if (start && !busy) begin
        fresh = apply_request(req_op, req_time, req_id, req_pos);
        pending_results.push_back(req_typed ? req_exp : fresh);
      end
    end
  end

  // called at a rising edge; returns at the edge that takes the request
  task automatic send_request(op_e op, logic [TIME_W-1:0] t, logic [ID_W-1:0] id,
                              logic [POS_W-1:0] pos, bit typed, alarm_result_t exp);
    start     <= 1'b1;
    req_op    <= op;
    req_time  <= t;
    req_id    <= id;
    req_pos   <= pos;
    req_typed <= typed;
    req_exp   <= exp;
    do @(posedge clk_i); while (busy);
  endtask

  // start low with junk on the request fields, which must be ignored
  task automatic idle_for(int n);
    for (int i = 0; i < n; i++) begin
      start    <= 1'b0;
      req_op   <= op_e'($urandom_range(3));
      req_time <= $urandom();
      req_id   <= ID_W'($urandom());
      req_pos  <= POS_W'($urandom());
      @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    int                sent;
    int                burst;
    int                gap;
    int                ins_weight;
    int                r;
    op_e               op;
    logic [TIME_W-1:0] t;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
    sent = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].op, dir_rows[k].t, dir_rows[k].id, dir_rows[k].pos,
                   dir_rows[k].typed, dir_rows[k].res);
      idle_for($urandom_range(0, 3));
    end

    while (sent < N_RANDOM) begin
      burst = ($urandom_range(7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        // alternate stretches that fill and drain the table
        ins_weight = ((sent / 64) % 2 == 0) ? 65 : 25;
        r = $urandom_range(99);
        if (r < ins_weight) begin
          op = OP_INSERT;
        end else begin
          case ($urandom_range(2))
            0:       op = OP_REMOVE_ID;
            1:       op = OP_REMOVE_POS;
            default: op = OP_READ;
          endcase
        end
        case ($urandom_range(3))
          0:       t = $urandom_range(15);
          1:       t = $urandom();
          2:       t = $urandom_range(1) ? 32'hFFFFFFFF : 32'd0;
          default: t = (tbl_count > 0) ? tbl_time[$urandom_range(tbl_count - 1)] : $urandom();
        endcase
        id = $urandom_range(1) ? ID_W'($urandom_range(7)) : ID_W'($urandom());
        if (op == OP_REMOVE_ID && tbl_count > 0 && $urandom_range(9) < 7)
          id = tbl_id[$urandom_range(tbl_count - 1)];
        if (tbl_count > 0 && $urandom_range(9) < 8)
          pos = POS_W'($urandom_range(tbl_count - 1));
        else
          pos = POS_W'($urandom_range(15));
        send_request(op, t, id, pos, 1'b0, '0);
        sent++;
      end
      r = $urandom_range(19);
      if (r < 5)       gap = 0;
      else if (r == 0) gap = 0;
      else if (r < 19) gap = $urandom_range(1, 8);
      else             gap = $urandom_range(20, 40);
      idle_for(gap);
    end

    start <= 1'b0;
    for (int w = 0; w < 400 && pending_results.size() != 0; w++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d results never arrived", pending_results.size());
      n_bad++;
    end
    if (n_bad == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
